[design/tcce_pkg.sv]
// Shared types, codes and constants for the text console cursor engine.
// No dependencies; imported by every module of the block.
package tcce_pkg;

   localparam int unsigned TEXT_WIDTH = 80;
   localparam int unsigned TAB_STOP   = 8;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET = 7'd25;
   localparam logic [7:0] ATTR_RESET = 8'h07;

   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_CURSOR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_COL_LIMIT = 2'd0,
      REG_ROW_LIMIT = 2'd1,
      REG_TEXT_ATTR = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0] col_limit;
      logic [6:0] row_limit;
      logic [7:0] text_attr;
   } cfg_type;

   // All results caused by one item
   typedef struct packed {
      logic        wr_valid;
      logic [7:0]  wr_col;
      logic [6:0]  wr_row;
      logic [7:0]  wr_char;
      logic        ev_valid;
      kind_type    ev_kind;
      logic [7:0]  attr;
      logic [7:0]  cur_col;
      logic [6:0]  cur_row;
      logic [15:0] cur_linear;
   } bundle_type;

endpackage

[design/tcce_csr.sv]
// Configuration registers of the cursor engine behind an APB-style port.
// Depends on tcce_pkg.
module tcce_csr import tcce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_COL_LIMIT: cfg_in.col_limit = csr_pwdata[7:0];
            REG_ROW_LIMIT: cfg_in.row_limit = csr_pwdata[6:0];
            REG_TEXT_ATTR: cfg_in.text_attr = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_COL_LIMIT: csr_prdata = {24'd0, cfg_ff.col_limit};
         REG_ROW_LIMIT: csr_prdata = {25'd0, cfg_ff.row_limit};
         REG_TEXT_ATTR: csr_prdata = {24'd0, cfg_ff.text_attr};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{col_limit: COLS_RESET, row_limit: ROWS_RESET, text_attr: ATTR_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/tcce_step.sv]
// Input register, cursor state and the single-pass cursor update logic.
// Depends on tcce_pkg; hands a result bundle to tcce_emit.
module tcce_step import tcce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_char,
   input  logic [7:0] req_new_col,
   input  logic [6:0] req_new_row,
   input  logic       bundle_space,
   output logic       bundle_load,
   output bundle_type bundle
);

   logic       item_valid_ff, item_valid_in;
   logic [1:0] mode_ff;
   logic [7:0] char_ff;
   logic [7:0] new_col_ff;
   logic [6:0] new_row_ff;
   logic [7:0] col_ff, col_in;
   logic [6:0] row_ff, row_in;

   logic [7:0] eff_cols;
   logic [6:0] eff_rows;
   logic [8:0] tab_next;
   logic [8:0] col_inc;
   logic [7:0] row_inc;
   logic       new_line;
   logic       req_take;

   assign eff_cols = (cfg.col_limit == 8'd0) ? 8'd1 : cfg.col_limit;
   assign eff_rows = (cfg.row_limit == 7'd0) ? 7'd1 : cfg.row_limit;
   assign tab_next = 9'((({1'b0, col_ff} / TAB_STOP) + 9'd1) * TAB_STOP);
   assign col_inc  = {1'b0, col_ff} + 9'd1;
   assign row_inc  = {1'b0, row_ff} + 8'd1;

   assign bundle_load   = item_valid_ff & bundle_space;
   assign req_tready    = ~item_valid_ff | bundle_load;
   assign req_take      = req_tvalid & req_tready;
   assign item_valid_in = req_take | (item_valid_ff & ~bundle_load);

   always_comb begin
      bundle          = '0;
      bundle.ev_kind  = KIND_SCROLL;
      bundle.attr     = cfg.text_attr;
      bundle.wr_col   = col_ff;
      bundle.wr_row   = row_ff;
      bundle.wr_char  = char_ff;
      new_line        = 1'b0;
      col_in          = col_ff;
      row_in          = row_ff;
      case (mode_ff)
         MODE_PUT: begin
            unique case (char_ff)
               CHAR_LF: begin
                  col_in   = 8'd0;
                  new_line = 1'b1;
               end
               CHAR_CR: col_in = 8'd0;
               CHAR_BS: begin
                  if (col_ff != 8'd0) begin
                     col_in          = col_ff - 8'd1;
                     bundle.wr_valid = 1'b1;
                     bundle.wr_col   = col_ff - 8'd1;
                     bundle.wr_char  = CHAR_SPACE;
                  end else if (row_ff != 7'd0) begin
                     row_in          = row_ff - 7'd1;
                     col_in          = eff_cols - 8'd1;
                     bundle.wr_valid = 1'b1;
                     bundle.wr_col   = eff_cols - 8'd1;
                     bundle.wr_row   = row_ff - 7'd1;
                     bundle.wr_char  = CHAR_SPACE;
                  end
               end
               CHAR_TAB: begin
                  if (tab_next >= {1'b0, eff_cols}) begin
                     col_in   = 8'd0;
                     new_line = 1'b1;
                  end else begin
                     col_in = tab_next[7:0];
                  end
               end
               default: begin
                  bundle.wr_valid = 1'b1;
                  if (col_inc >= {1'b0, eff_cols}) begin
                     col_in   = 8'd0;
                     new_line = 1'b1;
                  end else begin
                     col_in = col_inc[7:0];
                  end
               end
            endcase
            if (new_line) begin
               if (row_inc >= {1'b0, eff_rows}) begin
                  row_in          = eff_rows - 7'd1;
                  bundle.ev_valid = 1'b1;
               end else begin
                  row_in = row_inc[6:0];
               end
            end
         end
         MODE_SET: begin
            if (new_col_ff < eff_cols) col_in = new_col_ff;
            if (new_row_ff < eff_rows) row_in = new_row_ff;
         end
         MODE_CLEAR: begin
            bundle.ev_valid = 1'b1;
            bundle.ev_kind  = KIND_CLEAR;
            col_in          = 8'd0;
            row_in          = 7'd0;
         end
         default: ;
      endcase
      bundle.cur_col    = col_in;
      bundle.cur_row    = row_in;
      bundle.cur_linear = ({9'd0, row_in} * 16'(TEXT_WIDTH)) + {8'd0, col_in};
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff    <= req_mode;
         char_ff    <= req_char;
         new_col_ff <= req_new_col;
         new_row_ff <= req_new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         col_ff        <= 8'd0;
         row_ff        <= 7'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (bundle_load) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

[design/tcce_emit.sv]
// Result register: holds one item's results and sends them one per transfer.
// Depends on tcce_pkg; fed by tcce_step.
module tcce_emit import tcce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        bundle_load,
   input  bundle_type  bundle,
   output logic        bundle_space,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   bundle_type bundle_ff;
   logic [2:0] pend_ff, pend_in;
   logic       sent;
   kind_type   kind;
   logic [7:0] cell_col;
   logic [6:0] cell_row;
   logic [7:0] cell_char;
   logic [7:0] cell_attr;

   assign rsp_tvalid   = |pend_ff;
   assign rsp_tlast    = (pend_ff == 3'b100);
   assign sent         = rsp_tvalid & rsp_tready;
   assign bundle_space = ~rsp_tvalid | (sent & rsp_tlast);

   always_comb begin
      pend_in = pend_ff;
      if (bundle_load) begin
         pend_in = {1'b1, bundle.ev_valid, bundle.wr_valid};
      end else if (sent) begin
         pend_in = pend_ff & (pend_ff - 3'd1);
      end
   end

   always_comb begin
      kind      = KIND_CURSOR;
      cell_col  = 8'd0;
      cell_row  = 7'd0;
      cell_char = 8'd0;
      cell_attr = 8'd0;
      if (pend_ff[0]) begin
         kind      = KIND_WRITE;
         cell_col  = bundle_ff.wr_col;
         cell_row  = bundle_ff.wr_row;
         cell_char = bundle_ff.wr_char;
         cell_attr = bundle_ff.attr;
      end else if (pend_ff[1]) begin
         kind      = bundle_ff.ev_kind;
         cell_char = CHAR_SPACE;
         cell_attr = bundle_ff.attr;
      end
   end

   assign rsp_tuser = kind;
   assign rsp_tdata = {2'd0, bundle_ff.cur_linear, bundle_ff.cur_row, bundle_ff.cur_col,
                       cell_attr, cell_char, cell_row, cell_col};

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         bundle_ff <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'b000;
      end else begin
         pend_ff <= pend_in;
      end
   end

endmodule

[design/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: configuration, cursor step, result sender.
// Depends on tcce_pkg, tcce_csr, tcce_step and tcce_emit.
//
//   channel  ports   direction  carries
//   request  req_*   in         one item: put character, set cursor or clear
//   result   rsp_*   out        cell write, scroll or clear, cursor update
//   config   csr_*   in/out     column limit, row limit, text attribute
//
// An item yields one to three results, one transfer per cycle on the result
// channel while rsp_tready is high; a stalled receiver holds the transfers.
// The input register takes a new item while the previous one's results are
// still being sent; with both registers full, req_tready follows the last one.
// Reset puts the cursor at (0,0) and the registers at 80, 25 and 0x07.
module text_console_cursor_engine import tcce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // char_code[7:0], new_col[15:8], new_row[22:16]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // cell_col, cell_row, cell_char, cell_attr,
                                   // cursor_col, cursor_row, cursor_linear
   output logic [1:0]  rsp_tuser,  // kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   bundle_type bundle;
   logic       bundle_load;
   logic       bundle_space;

   tcce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcce_step u_step (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_mode     (req_tuser),
      .req_char     (req_tdata[7:0]),
      .req_new_col  (req_tdata[15:8]),
      .req_new_row  (req_tdata[22:16]),
      .bundle_space (bundle_space),
      .bundle_load  (bundle_load),
      .bundle       (bundle)
   );

   tcce_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .bundle_load  (bundle_load),
      .bundle       (bundle),
      .bundle_space (bundle_space),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

[tb/tb.sv]
// Self-checking bench for text_console_cursor_engine: directed script, then random phases.
// Predicts cell writes, scrolls, clears and cursor updates; depends on tcce_pkg and the RTL.
`timescale 1ns / 1ps

module tb import tcce_pkg::*;;

   localparam logic [1:0] MODE_UNDEF = 2'd3;
   localparam int SCRIPT_LEN = 23;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 62;
   localparam int TAIL_CYCLES = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic        last;
      logic [1:0]  kind;
      logic [1:0]  pad;
      logic [15:0] cursor_linear;
      logic [6:0]  cursor_row;
      logic [7:0]  cursor_col;
      logic [7:0]  cell_attr;
      logic [7:0]  cell_char;
      logic [6:0]  cell_row;
      logic [7:0]  cell_col;
   } console_result_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] ch;
      logic [7:0] nc;
      logic [6:0] nr;
      logic       typed;
      logic [7:0] tcol;
      logic [6:0] trow;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // char_code[7:0], new_col[15:8], new_row[22:16]
   logic [1:0]  req_tuser = '0;  // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // cell_col, cell_row, cell_char, cell_attr,
                                 // cursor_col, cursor_row, cursor_linear
   logic [1:0]  rsp_tuser;       // kind[1:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_console_cursor_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   console_result_type pending_results[$];
   logic [7:0]  cur_col = '0;
   logic [6:0]  cur_row = '0;
   logic [7:0]  cols_reg = COLS_RESET;
   logic [6:0]  rows_reg = ROWS_RESET;
   logic [7:0]  attr_reg = ATTR_RESET;
   int unsigned idle_pct = 20;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_count = 0;

   script_row_type directed_script [SCRIPT_LEN] = '{
      '{MODE_PUT,   8'h41,      8'h00, 7'h00, 1'b1, 8'd1,  7'd0},
      '{MODE_PUT,   CHAR_BS,    8'hFF, 7'h7F, 1'b1, 8'd0,  7'd0},
      '{MODE_PUT,   CHAR_BS,    8'h00, 7'h00, 1'b1, 8'd0,  7'd0},
      '{MODE_PUT,   CHAR_TAB,   8'h00, 7'h00, 1'b1, 8'd8,  7'd0},
      '{MODE_PUT,   CHAR_TAB,   8'h00, 7'h00, 1'b0, 8'd0,  7'd0},
      '{MODE_PUT,   CHAR_CR,    8'h00, 7'h00, 1'b1, 8'd0,  7'd0},
      '{MODE_PUT,   CHAR_LF,    8'h00, 7'h00, 1'b1, 8'd0,  7'd1},
      '{MODE_PUT,   CHAR_BS,    8'h00, 7'h00, 1'b1, 8'd79, 7'd0},
      '{MODE_PUT,   8'hFF,      8'h00, 7'h00, 1'b1, 8'd0,  7'd1},
      '{MODE_SET,   8'hFF,      8'd79, 7'd24, 1'b1, 8'd79, 7'd24},
      '{MODE_PUT,   8'h00,      8'h00, 7'h00, 1'b1, 8'd0,  7'd24},
      '{MODE_SET,   8'h00,      8'hFF, 7'h7F, 1'b1, 8'd0,  7'd24},
      '{MODE_SET,   8'h00,      8'd72, 7'd24, 1'b0, 8'd0,  7'd0},
      '{MODE_PUT,   CHAR_TAB,   8'h00, 7'h00, 1'b1, 8'd0,  7'd24},
      '{MODE_PUT,   CHAR_LF,    8'h00, 7'h00, 1'b1, 8'd0,  7'd24},
      '{MODE_UNDEF, 8'hFF,      8'hFF, 7'h7F, 1'b1, 8'd0,  7'd24},
      '{MODE_CLEAR, 8'hFF,      8'hFF, 7'h7F, 1'b1, 8'd0,  7'd0},
      '{MODE_SET,   8'h00,      8'd80, 7'd25, 1'b1, 8'd0,  7'd0},
      '{MODE_SET,   8'h00,      8'd79, 7'd0,  1'b0, 8'd0,  7'd0},
      '{MODE_PUT,   CHAR_SPACE, 8'h00, 7'h00, 1'b0, 8'd0,  7'd0},
      '{MODE_SET,   8'h00,      8'd5,  7'd3,  1'b0, 8'd0,  7'd0},
      '{MODE_PUT,   8'h7F,      8'h00, 7'h00, 1'b0, 8'd0,  7'd0},
      '{MODE_UNDEF, 8'h00,      8'h00, 7'h00, 1'b1, 8'd6,  7'd3}
   };

   function automatic string describe(console_result_type r);
      return $sformatf({"kind %0d cell (%0d,%0d) char %h attr %h ",
                        "cursor (%0d,%0d) lin %0d last %0d pad %0d"},
                       r.kind, r.cell_col, r.cell_row, r.cell_char, r.cell_attr,
                       r.cursor_col, r.cursor_row, r.cursor_linear, r.last, r.pad);
   endfunction

   function automatic void add_cmd(logic [1:0] kind, logic [7:0] col, logic [6:0] row,
                                   logic [7:0] ch, logic [7:0] attr);
      console_result_type r;
      r = '0;
      r.kind = kind;
      r.cell_col = col;
      r.cell_row = row;
      r.cell_char = ch;
      r.cell_attr = attr;
      pending_results.push_back(r);
   endfunction

   function automatic void stamp_cursor(int n);
      int base;
      base = pending_results.size() - n;
      for (int i = 0; i < n; i++) begin
         pending_results[base + i].cursor_col = cur_col;
         pending_results[base + i].cursor_row = cur_row;
         pending_results[base + i].cursor_linear = 16'(int'(cur_row) * TEXT_WIDTH + cur_col);
         pending_results[base + i].last = (i == n - 1);
      end
   endfunction

   function automatic int rows_in_use();
      return (rows_reg == 0) ? 1 : int'(rows_reg);
   endfunction

   function automatic int cols_in_use();
      return (cols_reg == 0) ? 1 : int'(cols_reg);
   endfunction

   function automatic bit next_row();
      if (int'(cur_row) + 1 >= rows_in_use()) begin
         cur_row = 7'(rows_in_use() - 1);
         return 1'b1;
      end
      cur_row = cur_row + 7'd1;
      return 1'b0;
   endfunction

   function automatic int console_step(logic [1:0] m, logic [7:0] ch, logic [7:0] nc,
                                       logic [6:0] nr);
      int n;
      int tab_col;
      bit scrolled;
      n = 0;
      scrolled = 1'b0;
      case (m)
         MODE_PUT: begin
            if (ch == CHAR_LF) begin
               cur_col = '0;
               scrolled = next_row();
            end else if (ch == CHAR_CR) begin
               cur_col = '0;
            end else if (ch == CHAR_BS) begin
               if (cur_col != 0) begin
                  cur_col = cur_col - 8'd1;
                  add_cmd(KIND_WRITE, cur_col, cur_row, CHAR_SPACE, attr_reg);
                  n++;
               end else if (cur_row != 0) begin
                  cur_row = cur_row - 7'd1;
                  cur_col = 8'(cols_in_use() - 1);
                  add_cmd(KIND_WRITE, cur_col, cur_row, CHAR_SPACE, attr_reg);
                  n++;
               end
            end else if (ch == CHAR_TAB) begin
               tab_col = (int'(cur_col) / int'(TAB_STOP) + 1) * int'(TAB_STOP);
               if (tab_col >= cols_in_use()) begin
                  cur_col = '0;
                  scrolled = next_row();
               end else begin
                  cur_col = 8'(tab_col);
               end
            end else begin
               add_cmd(KIND_WRITE, cur_col, cur_row, ch, attr_reg);
               n++;
               if (int'(cur_col) + 1 >= cols_in_use()) begin
                  cur_col = '0;
                  scrolled = next_row();
               end else begin
                  cur_col = cur_col + 8'd1;
               end
            end
            if (scrolled) begin
               add_cmd(KIND_SCROLL, '0, '0, CHAR_SPACE, attr_reg);
               n++;
            end
         end
         MODE_SET: begin
            if (int'(nc) < cols_in_use()) cur_col = nc;
            if (int'(nr) < rows_in_use()) cur_row = nr;
         end
         MODE_CLEAR: begin
            add_cmd(KIND_CLEAR, '0, '0, CHAR_SPACE, attr_reg);
            n++;
            cur_col = '0;
            cur_row = '0;
         end
         default: begin
         end
      endcase
      add_cmd(KIND_CURSOR, '0, '0, '0, '0);
      n++;
      stamp_cursor(n);
      return n;
   endfunction

   task automatic send_item(logic [1:0] m, logic [7:0] ch, logic [7:0] nc, logic [6:0] nr);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= m;
      req_tdata <= {1'b0, nr, nc, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_COL_LIMIT: cols_reg = val[7:0];
         REG_ROW_LIMIT: rows_reg = val[6:0];
         REG_TEXT_ATTR: attr_reg = val[7:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      console_result_type got;
      console_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tuser, rsp_tdata};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transfer: %s", describe(got));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch at %0t", $realtime);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int n;
      int pick;
      logic [1:0] m;
      logic [7:0] ch;
      logic [7:0] nc;
      logic [6:0] nr;
      logic [7:0] phase_cols [PHASES];
      logic [6:0] phase_rows [PHASES];
      logic [7:0] phase_attr [PHASES];
      logic [7:0] control_chars [4];

      phase_cols = '{8'd0, 8'd255, 8'd1, 8'd8, 8'd9, 8'd0, 8'd0, 8'd80};
      phase_rows = '{7'd0, 7'd127, 7'd1, 7'd3, 7'd2, 7'd0, 7'd0, 7'd25};
      phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'h1F, 8'hA5, 8'h00, 8'h00, 8'h07};
      control_chars = '{CHAR_BS, CHAR_TAB, CHAR_LF, CHAR_CR};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         n = console_step(directed_script[i].mode, directed_script[i].ch,
                          directed_script[i].nc, directed_script[i].nr);
         if (directed_script[i].typed) begin
            cur_col = directed_script[i].tcol;
            cur_row = directed_script[i].trow;
            stamp_cursor(n);
         end
         send_item(directed_script[i].mode, directed_script[i].ch,
                   directed_script[i].nc, directed_script[i].nr);
      end
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            idle_pct = 0;
         end else begin
            pick = $urandom_range(0, 2);
            idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
         end
         if (p == 5 || p == 6) begin
            phase_cols[p] = 8'($urandom_range(0, 255));
            phase_rows[p] = 7'($urandom_range(0, 127));
            phase_attr[p] = 8'($urandom_range(0, 255));
         end
         write_reg(REG_ROW_LIMIT, 32'(phase_rows[p]));
         write_reg(REG_COL_LIMIT, 32'(phase_cols[p]));
         write_reg(REG_TEXT_ATTR, 32'(phase_attr[p]));

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            ch = 8'($urandom_range(0, 255));
            nc = 8'($urandom_range(0, 255));
            nr = 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               m = MODE_PUT;
               if ($urandom_range(0, 99) < 40) ch = control_chars[$urandom_range(0, 3)];
            end else if (pick < 85) begin
               m = MODE_SET;
               if ($urandom_range(0, 3) != 0) begin
                  nc = 8'($urandom_range(0, cols_in_use()));
                  nr = 7'($urandom_range(0, rows_in_use() < 127 ? rows_in_use() : 127));
               end
            end else if (pick < 93) begin
               m = MODE_CLEAR;
            end else begin
               m = MODE_UNDEF;
            end
            n = console_step(m, ch, nc, nr);
            send_item(m, ch, nc, nr);
         end
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
